// ===== design/spq_pkg.sv =====
// Package for the sorted priority queue: depth, status and command codes, and the
// entry and command types that pass between the top level and the cells.
// No dependencies.
`default_nettype none

package spq_pkg;

   // Number of entries the queue holds.
   localparam int unsigned DEPTH = 16;

   // Command codes carried in the kind field of a request beat.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Status codes returned in a response beat.
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // One stored entry as held in a cell.
   typedef struct packed {
      logic        valid;
      logic [31:0] job;
      logic [31:0] prio;
   } entry_type;

   // Command broadcast to every cell in the cycle a request beat is taken.
   typedef struct packed {
      logic        insert;
      logic        remove;
      logic [31:0] job;
      logic [31:0] prio;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/spq_req_if.sv =====
// Request channel of the sorted priority queue: valid/ready handshake with the
// insert or remove command. Depends on nothing.
`default_nettype none

interface spq_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] job_number;
   logic signed [31:0] job_priority;

   modport source (output valid, output kind, output job_number, output job_priority,
                   input ready);
   modport sink   (input valid, input kind, input job_number, input job_priority,
                   output ready);
endinterface

`default_nettype wire

// ===== design/spq_rsp_if.sv =====
// Response channel of the sorted priority queue: valid/ready handshake with the
// status and the served entry. Depends on nothing.
`default_nettype none

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] served_job;
   logic signed [31:0] served_priority;

   modport source (output valid, output status, output served_job, output served_priority,
                   input ready);
   modport sink   (input valid, input status, input served_job, input served_priority,
                   output ready);
endinterface

`default_nettype wire

// ===== design/spq_cell.sv =====
// One cell of the sorted shift array: holds a single entry and updates it from the
// broadcast command and its two neighbors. Depends on spq_pkg.
`default_nettype none

module spq_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire spq_pkg::cmd_type   cmd,
   input  wire spq_pkg::entry_type left_entry,
   input  wire logic               left_ge,
   input  wire spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type      entry,
   output logic                    ge
);

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] job_ff;
   logic [31:0] job_in;
   logic [31:0] prio_ff;
   logic [31:0] prio_in;

   // An empty cell acts as an infinitely large priority, so the new entry lands
   // in the first cell whose priority is at least its own.
   assign ge = !valid_ff || ($signed(prio_ff) >= $signed(cmd.prio));

   assign entry = '{valid: valid_ff, job: job_ff, prio: prio_ff};

   // Insert shifts the tail right from the landing cell; remove shifts all left.
   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      prio_in  = prio_ff;
      if (cmd.insert && ge) begin
         if (left_ge) begin
            valid_in = left_entry.valid;
            job_in   = left_entry.job;
            prio_in  = left_entry.prio;
         end else begin
            valid_in = 1'b1;
            job_in   = cmd.job;
            prio_in  = cmd.prio;
         end
      end else if (cmd.remove) begin
         valid_in = right_entry.valid;
         job_in   = right_entry.job;
         prio_in  = right_entry.prio;
      end
   end

   // The valid bit is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The payload needs no reset; an invalid cell's contents are never served.
   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      prio_ff <= prio_in;
   end

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue_unit.sv =====
// Sorted priority queue built as a row of DEPTH cells kept in ascending priority
// order, head in cell 0; a new entry goes ahead of stored entries of equal
// priority. A request beat is taken whenever the response register is empty or
// is drained in the same cycle. Each beat updates every cell at once through a
// single signed compare and a neighbor select in each cell, so the rate is one
// beat per cycle while that register is free; the response appears in it in the
// cycle after the request is taken. Inserting into a full queue returns the full
// status and removing from an empty queue returns the empty status, both with
// zero job and priority. No clearing pass is needed after reset.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
`default_nettype none

module sorted_priority_queue_unit (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   spq_pkg::entry_type   cell_entry [spq_pkg::DEPTH];
   logic                 cell_ge    [spq_pkg::DEPTH];
   logic [spq_pkg::DEPTH-1:0] cell_valid;
   spq_pkg::cmd_type     cmd;
   logic                 req_accept;
   logic                 queue_full;
   logic                 queue_empty;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   spq_pkg::status_type  rsp_status_ff;
   spq_pkg::status_type  rsp_status_in;
   logic [31:0]          rsp_job_ff;
   logic [31:0]          rsp_job_in;
   logic [31:0]          rsp_prio_ff;
   logic [31:0]          rsp_prio_in;

   // Valid bits are contiguous from the head, so the ends tell full and empty.
   assign queue_full  = cell_valid[spq_pkg::DEPTH-1];
   assign queue_empty = !cell_valid[0];

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // Command broadcast to the cells; refused beats leave the store unchanged.
   always_comb begin
      cmd.insert = req_accept && (req.kind == spq_pkg::KIND_INSERT) && !queue_full;
      cmd.remove = req_accept && (req.kind == spq_pkg::KIND_REMOVE) && !queue_empty;
      cmd.job    = req.job_number;
      cmd.prio   = req.job_priority;
   end

   // The row of cells, each wired to its left and right neighbors.
   for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      logic               left_ge;
      spq_pkg::entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_ge    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == spq_pkg::DEPTH - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );

      assign cell_valid[i] = cell_entry[i].valid;
   end

   // Response register: loaded on each taken beat, cleared when drained.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_job_in    = rsp_job_ff;
      rsp_prio_in   = rsp_prio_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_job_in   = '0;
         rsp_prio_in  = '0;
         if (req.kind == spq_pkg::KIND_INSERT) begin
            rsp_status_in = queue_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
         end else if (queue_empty) begin
            rsp_status_in = spq_pkg::ST_EMPTY;
         end else begin
            rsp_status_in = spq_pkg::ST_REMOVED;
            rsp_job_in    = cell_entry[0].job;
            rsp_prio_in   = cell_entry[0].prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_job_ff    <= rsp_job_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.served_job      = rsp_job_ff;
   assign rsp.served_priority = rsp_prio_ff;

   // Occupied cells always form an unbroken run starting at the head.
   a_valid_contiguous : assert property (@(posedge clock) disable iff (reset)
      ((cell_valid + 1'b1) & cell_valid) == '0)
      else $error("occupied cells are not contiguous from the head");

   // A successful insert adds exactly one occupied cell.
   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> $countones(cell_valid) == $countones($past(cell_valid)) + 1)
      else $error("insert did not add exactly one entry");

   // A successful remove frees exactly one occupied cell.
   a_remove_shrinks : assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> $countones(cell_valid) + 1 == $countones($past(cell_valid)))
      else $error("remove did not free exactly one entry");

   // Only a removed status carries a served entry.
   a_zero_payload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != spq_pkg::ST_REMOVED)
         |-> (rsp_job_ff == '0 && rsp_prio_ff == '0))
      else $error("non-remove response carries a nonzero entry");

   // Neighboring occupied cells stay in ascending priority order.
   for (genvar k = 0; k < spq_pkg::DEPTH - 1; k++) begin : g_order_check
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         cell_valid[k+1] |-> ($signed(cell_entry[k].prio) <= $signed(cell_entry[k+1].prio)))
         else $error("stored priorities are out of order");
   end

endmodule

`default_nettype wire

// ===== test/sorted_priority_queue_unit_tb.sv =====
// Testbench for sorted_priority_queue_unit. It predicts every response from its own model of
// the sorted store and drives inserts and removes with random gaps on both channels.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and the sorted_priority_queue_unit RTL.
`timescale 1ns / 100ps

module sorted_priority_queue_unit_tb;

   // One predicted response beat.
   typedef struct {
      spq_pkg::status_type status;
      logic signed [31:0]  job;
      logic signed [31:0]  prio;
   } served_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();

   sorted_priority_queue_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #10 clock = ~clock;

   // Shadow copy of the queue contents, head at index 0.
   logic signed [31:0] shadow_jobs  [spq_pkg::DEPTH];
   logic signed [31:0] shadow_prios [spq_pkg::DEPTH];
   int                 shadow_count = 0;

   served_type pending_served [$];
   int         mismatch_count = 0;
   bit         sender_idles = 1'b1;
   bit         receiver_stalls = 1'b1;
   int         stall_left = 0;

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_cycles(bit enable);
      int r;
      r = $urandom_range(0, 99);
      if (!enable || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   // Priorities drawn from a narrow band for ties, from the extremes, or from the whole range.
   function automatic logic signed [31:0] pick_priority();
      int v;
      case ($urandom_range(0, 3))
         0: begin
            v = $urandom_range(0, 8);
            return v - 4;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sh0000_0000;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Applies one command to the shadow queue and returns the response it must produce.
   function automatic served_type apply_command(logic kind, logic signed [31:0] job,
                                                logic signed [31:0] prio);
      served_type r;
      int         pos;
      r.status = spq_pkg::ST_INSERTED;
      r.job    = '0;
      r.prio   = '0;
      if (kind == spq_pkg::KIND_INSERT) begin
         if (shadow_count >= spq_pkg::DEPTH) begin
            r.status = spq_pkg::ST_FULL;
         end else begin
            // The new entry goes ahead of the first entry whose priority is not lower.
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_prios[i] >= prio) begin
                  pos = i;
                  break;
               end
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_jobs[i]  = shadow_jobs[i-1];
               shadow_prios[i] = shadow_prios[i-1];
            end
            shadow_jobs[pos]  = job;
            shadow_prios[pos] = prio;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = spq_pkg::ST_EMPTY;
      end else begin
         r.status = spq_pkg::ST_REMOVED;
         r.job    = shadow_jobs[0];
         r.prio   = shadow_prios[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_jobs[i-1]  = shadow_jobs[i];
            shadow_prios[i-1] = shadow_prios[i];
         end
         shadow_count--;
      end
      return r;
   endfunction

   // Sends one request beat after a random gap; valid stays high for a following beat.
   task automatic send_command(logic kind, logic signed [31:0] job, logic signed [31:0] prio);
      int gap;
      gap = idle_cycles(sender_idles);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.job_number   <= job;
      req_ch.job_priority <= prio;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_served.push_back(apply_command(kind, job, prio));
   endtask

   task automatic note_mismatch(string what, served_type want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected status %0d job %0d prio %0d, got status %0d job %0d prio %0d",
                  $realtime, what, want.status, want.job, want.prio,
                  rsp_ch.status, rsp_ch.served_job, rsp_ch.served_priority);
      end
   endtask

   // Checks each response beat against the oldest prediction and drives ready with stalls.
   always @(posedge clock) begin : check_served
      served_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_served.size() == 0) begin
            want.status = spq_pkg::ST_INSERTED;
            want.job    = '0;
            want.prio   = '0;
            note_mismatch("response beat with none expected", want);
         end else begin
            want = pending_served.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.served_job !== want.job ||
                rsp_ch.served_priority !== want.prio) begin
               note_mismatch("response mismatch", want);
            end
         end
      end
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = idle_cycles(1'b1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // A remove on the empty queue returns the empty status; its payload is ignored.
   task automatic test_remove_empty();
      send_command(spq_pkg::KIND_REMOVE, 32'sh7FFF_FFFF, 32'sh8000_0000);
   endtask

   // Fills the queue with extreme fields, including equal priorities landing at the head.
   task automatic test_fill_extremes();
      logic signed [31:0] jobs [16] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                                        32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6,
                                        32'sd7, 32'sd8, 32'sd9, 32'sd10, 32'sd11, 32'sd12};
      logic signed [31:0] prios [16] = '{32'sd0, 32'sd0, 32'sh8000_0000, 32'sh8000_0000,
                                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sd1, 32'sd1,
                                         32'sd100, -32'sd100, 32'sd5, 32'sd5, 32'sd7,
                                         32'sd0, 32'sd3, 32'sd2};
      for (int i = 0; i < 16; i++) send_command(spq_pkg::KIND_INSERT, jobs[i], prios[i]);
   endtask

   // An insert into the full queue is refused; a few removes then show the order.
   task automatic test_full_refusal();
      send_command(spq_pkg::KIND_INSERT, $urandom, pick_priority());
      repeat (4) send_command(spq_pkg::KIND_REMOVE, $urandom, $urandom);
   endtask

   // Random commands with a given share of inserts, which steers the fill level.
   task automatic test_random_traffic(int beats, int insert_pct);
      logic kind;
      repeat (beats) begin
         kind = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT
                                                     : spq_pkg::KIND_REMOVE;
         send_command(kind, $urandom, pick_priority());
      end
   endtask

   // Full-rate stretch with no idling on either side.
   task automatic test_back_to_back();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_random_traffic(200, 50);
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.kind         = spq_pkg::KIND_INSERT;
      req_ch.job_number   = '0;
      req_ch.job_priority = '0;
      rsp_ch.ready        = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_remove_empty();
      test_fill_extremes();
      test_full_refusal();
      test_random_traffic(300, 80);
      test_random_traffic(300, 20);
      test_random_traffic(300, 55);
      test_random_traffic(250, 90);
      test_random_traffic(250, 10);
      test_random_traffic(200, 50);
      test_back_to_back();

      // Drain the remaining responses, then let the response channel settle.
      req_ch.valid <= 1'b0;
      while (pending_served.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #10ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sorted_priority_queue_unit.f =====
design/spq_pkg.sv
design/spq_req_if.sv
design/spq_rsp_if.sv
design/spq_cell.sv
design/sorted_priority_queue_unit.sv
test/sorted_priority_queue_unit_tb.sv
